>>> rtl/core/asg_pkg.sv
package asg_pkg;

  // default element width, signed Q4.(width-4)
  localparam int unsigned ASG_DATA_WIDTH = 16;

  // pi/2 in unsigned Q1.16, rounded
  localparam int unsigned ASG_PI_HALF_W = 17;
  localparam logic [ASG_PI_HALF_W-1:0] ASG_PI_HALF_Q16 = 17'd102944;

  typedef enum logic {
    ASG_OP_FWD = 1'b0,
    ASG_OP_BWD = 1'b1
  } asg_op_e;

endpackage

>>> rtl/core/atan_surrogate_spike_gradient.sv
// Arctangent surrogate spike unit, one tensor element per beat. With tuser at forward it
// returns the Heaviside spike of x (1.0 when x >= 0, else 0); at backward it returns
// grad_in * (alpha/2) / (1 + (pi/2 * alpha * x)^2), saturated to the signed range, and flags
// a clipped result on the output tuser. Input tdata carries x_value in the low half and
// grad_in in the high half, all signed Q4.(DATA_WIDTH-4); alpha is written through the
// config port (unsigned, reset 2.0); the user must do so only while no beats are in flight,
// as the unit itself does not enforce it. The unit takes one beat per clock and returns
// results in order: five stages for magnitudes, the three multiply stages and the denominator,
// DATA_WIDTH + 3 stages of a bit-per-stage restoring divider, and the sign/saturation
// stage feeding the output register. A stall on the output side freezes the whole pipeline.
module atan_surrogate_spike_gradient #(
  parameter int unsigned DATA_WIDTH = asg_pkg::ASG_DATA_WIDTH
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [DATA_WIDTH-1:0]                  cfg_wdata_i,     // alpha
  input  logic                                   s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_axis_tdata_i,  // x_value, grad_in
  input  logic [0:0]                             s_axis_tuser_i,  // opcode
  output logic                                   m_axis_tvalid_o,
  input  logic                                   m_axis_tready_i,
  output logic [((DATA_WIDTH+7)/8)*8-1:0]        m_axis_tdata_o,  // result_value
  output logic [0:0]                             m_axis_tuser_o   // saturated
);
  import asg_pkg::*;

  localparam int unsigned W    = DATA_WIDTH;
  localparam int unsigned FRAC = W - 4;
  localparam int unsigned HW   = 2 * W - 1;                 // numerator width
  localparam int unsigned QW   = HW - FRAC;                 // quotient width
  localparam int unsigned UAW  = W + 5;                     // scaled argument width
  localparam int unsigned UW   = (UAW > 32) ? 32 : UAW;     // squared part of it
  localparam int unsigned SW   = 2 * UW;
  localparam int unsigned DW   = SW - FRAC + 1;             // denominator width
  localparam int unsigned TPW  = W + 4 + ASG_PI_HALF_W;
  localparam int unsigned OUTW = ((DATA_WIDTH + 7) / 8) * 8;
  localparam int unsigned NS   = 5 + QW;                    // stages before the output reg

  localparam logic [W-1:0]  ALPHA_RESET = W'(2) << FRAC;
  localparam logic [W-1:0]  SPIKE_ONE   = W'(1) << FRAC;
  localparam logic [DW-1:0] D_ONE       = DW'(1) << FRAC;
  localparam logic [QW-1:0] Q_MIN_MAG   = QW'(1) << (W - 1);
  localparam logic [QW-1:0] Q_POS_MAX   = Q_MIN_MAG - QW'(1);

  typedef struct packed {
    logic            fwd;
    logic            spike;
    logic            gneg;
    logic [W-1:0]    xmag;
    logic [W-1:0]    gmag;
    logic [2*W-1:0]  p;
    logic [HW-1:0]   h;
    logic [UW-1:0]   us;
    logic            huge;
    logic [SW-1:0]   sq;
    logic [DW-1:0]   d;
    logic [DW-1:0]   rem;
    logic [QW-1:0]   q;
  } pipe_t;

  logic [W-1:0] alpha_q;
  logic         en;
  logic         valid_q [NS];
  pipe_t        pipe_q  [NS];
  pipe_t        pipe_d  [NS];
  logic         out_valid_q;
  logic [W-1:0] out_res_q, out_res_d;
  logic         out_sat_q, out_sat_d;

  logic [W-1:0]    x_in, g_in;
  logic [2*W-1:0]  p_prod, h_prod;
  logic [TPW-1:0]  tp;
  logic [UAW-1:0]  u;
  logic [DW:0]     div_sh [QW];
  logic [QW-1:0]   q_fin;

  // whole pipeline advances together; a full output register that is not taken holds it
  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RESET;
    end else if (cfg_we_i) begin
      alpha_q <= cfg_wdata_i;
    end
  end

  assign x_in = s_axis_tdata_i[W-1:0];
  assign g_in = s_axis_tdata_i[2*W-1:W];

  always_comb begin
    // stage 0: magnitudes and forward spike
    pipe_d[0]       = '0;
    pipe_d[0].fwd   = (asg_op_e'(s_axis_tuser_i[0]) == ASG_OP_FWD);
    pipe_d[0].spike = !x_in[W-1];
    pipe_d[0].gneg  = g_in[W-1];
    pipe_d[0].xmag  = x_in[W-1] ? (~x_in + W'(1)) : x_in;
    pipe_d[0].gmag  = g_in[W-1] ? (~g_in + W'(1)) : g_in;

    // stage 1: alpha*|x| and alpha/2*|g|
    p_prod      = (2*W)'(alpha_q) * (2*W)'(pipe_q[0].xmag);
    h_prod      = (2*W)'(alpha_q) * (2*W)'(pipe_q[0].gmag);
    pipe_d[1]   = pipe_q[0];
    pipe_d[1].p = p_prod;
    pipe_d[1].h = h_prod[2*W-1:1];

    // stage 2: scale by pi/2
    tp             = TPW'(pipe_q[1].p[2*W-1:FRAC]) * TPW'(ASG_PI_HALF_Q16);
    u              = tp[TPW-1:16];
    pipe_d[2]      = pipe_q[1];
    pipe_d[2].us   = u[UW-1:0];
    pipe_d[2].huge = ((u >> UW) != '0);

    // stage 3: square
    pipe_d[3]    = pipe_q[2];
    pipe_d[3].sq = SW'(pipe_q[2].us) * SW'(pipe_q[2].us);

    // stage 4: denominator, divider seeded with the numerator bits that give zero quotient
    pipe_d[4]     = pipe_q[3];
    pipe_d[4].d   = D_ONE + DW'(pipe_q[3].sq >> FRAC);
    pipe_d[4].rem = DW'(pipe_q[3].h[HW-1:QW]);
    pipe_d[4].q   = '0;

    // restoring divider, one quotient bit per stage
    for (int k = 0; k < QW; k++) begin
      div_sh[k]     = {pipe_q[4+k].rem, pipe_q[4+k].h[QW-1-k]};
      pipe_d[5+k]   = pipe_q[4+k];
      if (div_sh[k] >= {1'b0, pipe_q[4+k].d}) begin
        pipe_d[5+k].rem = DW'(div_sh[k] - {1'b0, pipe_q[4+k].d});
        pipe_d[5+k].q   = {pipe_q[4+k].q[QW-2:0], 1'b1};
      end else begin
        pipe_d[5+k].rem = div_sh[k][DW-1:0];
        pipe_d[5+k].q   = {pipe_q[4+k].q[QW-2:0], 1'b0};
      end
    end
  end

  // sign and saturation
  always_comb begin
    q_fin     = pipe_q[NS-1].huge ? '0 : pipe_q[NS-1].q;
    out_sat_d = 1'b0;
    if (pipe_q[NS-1].fwd) begin
      out_res_d = pipe_q[NS-1].spike ? SPIKE_ONE : '0;
    end else if (pipe_q[NS-1].gneg) begin
      if (q_fin > Q_MIN_MAG) begin
        q_fin     = Q_MIN_MAG;
        out_sat_d = 1'b1;
      end
      out_res_d = W'(QW'(0) - q_fin);
    end else begin
      if (q_fin > Q_POS_MAX) begin
        q_fin     = Q_POS_MAX;
        out_sat_d = 1'b1;
      end
      out_res_d = W'(q_fin);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NS; i++) begin
        valid_q[i] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (en) begin
      valid_q[0] <= s_axis_tvalid_i;
      for (int i = 1; i < NS; i++) begin
        valid_q[i] <= valid_q[i-1];
      end
      out_valid_q <= valid_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NS; i++) begin
        pipe_q[i] <= pipe_d[i];
      end
      out_res_q <= out_res_d;
      out_sat_q <= out_sat_d;
    end
  end

  assign m_axis_tvalid_o   = out_valid_q;
  assign m_axis_tdata_o    = OUTW'(out_res_q);
  assign m_axis_tuser_o[0] = out_sat_q;

  // a clipped result sits at one end of the range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |->
      (out_res_q == {1'b0, {(W-1){1'b1}}} || out_res_q == {1'b1, {(W-1){1'b0}}}))
    else $error("saturated beat not at range limit");

  // a held result blocks new input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted while output stalled");

  // nothing in flight moves during a stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(valid_q[NS-1]) && $stable(valid_q[0]) && $stable(out_res_q)))
    else $error("pipeline moved during stall");

endmodule

>>> tb/sv/tb_atan_surrogate_spike_gradient.sv
module tb_atan_surrogate_spike_gradient;
  timeunit 1ns;
  timeprecision 1ps;

  import asg_pkg::*;

  localparam int unsigned DW = ASG_DATA_WIDTH;
  localparam int unsigned FRAC = DW - 4;
  localparam logic [DW-1:0] ONE_Q = DW'(1) << FRAC;
  localparam logic [DW-1:0] ALPHA_RESET = DW'(2) << FRAC;
  localparam logic [DW-1:0] POS_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] NEG_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [63:0] SIGN_MAG = 64'd1 << (DW - 1);
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned SETTLE_CYCLES = DW + 15;
  localparam int unsigned STALL_LIMIT = 4000;

  typedef struct packed {
    asg_op_e       op;
    logic [DW-1:0] x;
    logic [DW-1:0] g;
  } spike_item_t;

  typedef struct packed {
    logic [DW-1:0] value;
    logic          sat;
  } grad_beat_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [DW-1:0]               cfg_wdata = '0;
  logic                        beat_valid = 1'b0;
  logic                        beat_ready;
  logic [((2*DW+7)/8)*8-1:0]   beat_tdata = '0;
  logic [0:0]                  beat_tuser = '0;
  logic                        res_valid;
  logic                        res_ready = 1'b0;
  logic [((DW+7)/8)*8-1:0]     res_tdata;
  logic [0:0]                  res_tuser;

  spike_item_t pending_q[$];
  grad_beat_t  grad_expect_q[$];
  spike_item_t offered_item = '0;
  spike_item_t fetched;
  grad_beat_t  got_expect;
  logic [DW-1:0] sharp_alpha = ALPHA_RESET;
  bit          calm = 1'b0;
  int          mismatches = 0;
  int          hold_asks = 0;
  int          hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned src_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned stall_cycles = 0;

  atan_surrogate_spike_gradient #(.DATA_WIDTH(DW)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (beat_valid),
    .s_axis_tready_o (beat_ready),
    .s_axis_tdata_i  (beat_tdata),
    .s_axis_tuser_i  (beat_tuser),
    .m_axis_tvalid_o (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (res_tdata),
    .m_axis_tuser_o  (res_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // forward spike or arctangent surrogate gradient, the gradient computed on magnitudes
  function automatic grad_beat_t atan_grad_predict(spike_item_t it, logic [DW-1:0] a);
    grad_beat_t  r;
    longint      xs;
    longint      gs;
    logic [63:0] xm, gm, t, u, d, h, q;
    r = '0;
    xs = longint'($signed(it.x));
    gs = longint'($signed(it.g));
    if (it.op == ASG_OP_FWD) begin
      r.value = (xs >= 0) ? ONE_Q : '0;
    end else begin
      xm = (xs < 0) ? -xs : xs;
      gm = (gs < 0) ? -gs : gs;
      t = (xm * a) >> FRAC;
      u = (t * ASG_PI_HALF_Q16) >> 16;
      d = (u >= 64'h1_0000_0000) ? '1 : (64'd1 << FRAC) + ((u * u) >> FRAC);
      h = (gm * a) >> 1;
      q = h / d;
      if (gs < 0) begin
        if (q > SIGN_MAG) begin
          q = SIGN_MAG;
          r.sat = 1'b1;
        end
        r.value = ~q[DW-1:0] + 1'b1;
      end else begin
        if (q > {1'b0, POS_MAX}) begin
          q = 64'(POS_MAX);
          r.sat = 1'b1;
        end
        r.value = q[DW-1:0];
      end
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] pick_membrane();
    case ($urandom_range(0, 4))
      0, 1: return DW'($urandom);
      2: return DW'($urandom_range(0, 1023) - 512);
      3: return DW'($urandom_range(0, 31) - 16);
      default: begin
        case ($urandom_range(0, 3))
          0: return '0;
          1: return '1;
          2: return POS_MAX;
          default: return NEG_MIN;
        endcase
      end
    endcase
  endfunction

  function automatic logic [DW-1:0] pick_gradient();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return $urandom_range(0, 1) ? POS_MAX : NEG_MIN;
      2: return DW'($urandom_range(0, 255) - 128);
      default: return DW'($urandom);
    endcase
  endfunction

  task automatic queue_item(asg_op_e op, logic [DW-1:0] x, logic [DW-1:0] g);
    spike_item_t it;
    it.op = op;
    it.x = x;
    it.g = g;
    pending_q.push_back(it);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) begin
      queue_item(asg_op_e'($urandom_range(0, 1)), pick_membrane(), pick_gradient());
    end
  endtask

  // sender holds back until every result is home, then lets the pipe empty
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || beat_valid || grad_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_alpha(logic [DW-1:0] a);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= a;
    sharp_alpha = a;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // input side: offers queued items, with short random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (beat_valid && beat_ready) begin
        grad_expect_q.push_back(atan_grad_predict(offered_item, sharp_alpha));
      end
      if (!beat_valid || beat_ready) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          beat_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          src_gap <= $urandom_range(0, 2);
          beat_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          fetched = pending_q.pop_front();
          offered_item <= fetched;
          beat_tdata <= {fetched.g, fetched.x};
          beat_tuser <= fetched.op;
          beat_valid <= 1'b1;
        end else begin
          beat_valid <= 1'b0;
        end
      end
    end
  end

  // output side: checks each result beat, stalls at random or on a long hold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready <= 1'b0;
      sink_gap <= 0;
      hold_left <= 0;
    end else begin
      if (res_valid && res_ready) begin
        if (grad_expect_q.size() == 0) begin
          $error("result beat with nothing expected: result_value %0d saturated %0d",
                 $signed(res_tdata[DW-1:0]), res_tuser);
          mismatches++;
        end else begin
          got_expect = grad_expect_q.pop_front();
          if (res_tdata[DW-1:0] !== got_expect.value) begin
            $error("result_value expected %0d got %0d", $signed(got_expect.value),
                   $signed(res_tdata[DW-1:0]));
            mismatches++;
          end
          if (res_tuser[0] !== got_expect.sat) begin
            $error("saturated expected %0d got %0d", got_expect.sat, res_tuser[0]);
            mismatches++;
          end
        end
      end
      if (hold_served != hold_asks) begin
        hold_served <= hold_asks;
        hold_left <= HOLD_CYCLES - 1;
        res_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        res_ready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap <= sink_gap - 1;
        res_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        sink_gap <= $urandom_range(0, 2);
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no beat moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (beat_valid && beat_ready) || (res_valid && res_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [DW-1:0] a;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset alpha of 2.0: spike edges, exact negative limit, exact positive limit
    queue_item(ASG_OP_FWD, '0, '0);
    queue_item(ASG_OP_FWD, '1, POS_MAX);
    queue_item(ASG_OP_FWD, POS_MAX, NEG_MIN);
    queue_item(ASG_OP_FWD, NEG_MIN, '1);
    queue_item(ASG_OP_BWD, '0, NEG_MIN);
    queue_item(ASG_OP_BWD, '0, POS_MAX);
    queue_item(ASG_OP_BWD, '0, '0);
    queue_item(ASG_OP_BWD, 16'd1, 16'd1);
    queue_item(ASG_OP_BWD, '1, '1);
    queue_item(ASG_OP_BWD, NEG_MIN, POS_MAX);
    queue_item(ASG_OP_BWD, POS_MAX, NEG_MIN);
    queue_item(ASG_OP_BWD, 16'h0800, 16'h1000);
    wait_drained();

    // sharpest alpha: clipping both ways
    set_alpha('1);
    queue_item(ASG_OP_BWD, '0, POS_MAX);
    queue_item(ASG_OP_BWD, '0, NEG_MIN);
    queue_item(ASG_OP_BWD, NEG_MIN, POS_MAX);
    queue_item(ASG_OP_BWD, 16'd1, '1);
    queue_item(ASG_OP_FWD, 16'd1, POS_MAX);
    wait_drained();

    // zero alpha gives zero gradient
    set_alpha('0);
    queue_item(ASG_OP_BWD, '0, NEG_MIN);
    queue_item(ASG_OP_BWD, 16'h0123, POS_MAX);
    queue_item(ASG_OP_FWD, '1, '0);
    wait_drained();

    // just above 2.0 pushes the full positive gradient over the limit
    set_alpha(ALPHA_RESET + DW'(2));
    queue_item(ASG_OP_BWD, '0, POS_MAX);
    queue_item(ASG_OP_BWD, '0, NEG_MIN);
    queue_item(ASG_OP_BWD, 16'd1, 16'h4000);
    wait_drained();

    for (int k = 0; k < 8; k++) begin
      case ($urandom_range(0, 3))
        0: a = DW'($urandom);
        1: a = DW'($urandom_range(0, 4 << FRAC));
        2: a = $urandom_range(0, 1) ? '1 : 16'd1;
        default: a = DW'($urandom_range(1 << FRAC, 3 << FRAC));
      endcase
      set_alpha(a);
      if (k == 7) calm = 1'b1;
      queue_random(60);
      if (k == 3) hold_asks++;
      wait_drained();
    end

    if (mismatches == 0 && grad_expect_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/asg_pkg.sv
rtl/core/atan_surrogate_spike_gradient.sv
tb/sv/tb_atan_surrogate_spike_gradient.sv
